// ----- rtl/tpjq_pkg.sv -----
// Shared types, sizes and codes of the three-level priority job queue.
package tpjq_pkg;

    // Cells in each of the three queues.
    localparam int QUEUE_DEPTH = 64;
    // Width of a fill count, which must also hold QUEUE_DEPTH itself.
    localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

    localparam int ID_W    = 16;
    localparam int PAGES_W = 16;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    // Queue numbering inside the block.
    localparam int NUM_QUEUES = 3;
    localparam int Q_HIGH = 0;
    localparam int Q_MED  = 1;
    localparam int Q_LOW  = 2;

    // Level codes as reported on the result.
    localparam logic [1:0] LVL_NONE = 2'd0;
    localparam logic [1:0] LVL_LOW  = 2'd1;
    localparam logic [1:0] LVL_MED  = 2'd2;
    localparam logic [1:0] LVL_HIGH = 2'd3;

    localparam logic [1:0] PRIO_HIGH = 2'd3;
    localparam logic [1:0] PRIO_MED  = 2'd2;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_PROC   = 2'd1,
        REQ_CANCEL = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        STS_ADDED     = 3'd0,
        STS_ADD_FULL  = 3'd1,
        STS_DONE      = 3'd2,
        STS_FAIL_REQ  = 3'd3,
        STS_FAIL_DROP = 3'd4,
        STS_EMPTY     = 3'd5,
        STS_CANCELED  = 3'd6,
        STS_NOT_FOUND = 3'd7
    } t_status;

    typedef enum logic [2:0] {
        Q_NOP,
        Q_PUSH,
        Q_POP,
        Q_POP_PUSH,
        Q_CANCEL
    } t_qop;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [PAGES_W-1:0] pages;
        logic               failed;
    } t_job;

    // Per-cell control from the queue row.
    typedef struct packed {
        logic cap;
        logic shift;
        logic load;
    } t_cell_ctl;

    // Command from the controller to one queue.
    typedef struct packed {
        t_qop op;
        t_job job;
    } t_qcmd;

    // Status of one queue back to the controller.
    typedef struct packed {
        logic empty;
        logic full;
        logic hit;
        t_job head;
    } t_qstat;

endpackage

// ----- rtl/tpjq_cell.sv -----
// One cell of a queue row: holds one job and its id match flag.
module tpjq_cell import tpjq_pkg::*; (
    input  logic            i_clk,
    input  t_cell_ctl       i_ctl,
    input  t_job            i_next,
    input  t_job            i_new,
    input  logic [ID_W-1:0] i_key,
    input  logic            i_occ,
    output t_job            o_job,
    output logic            o_match
);

    t_job r_job;
    logic r_match;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_job <= i_new;
        end else if (i_ctl.shift) begin
            r_job <= i_next;
        end
        if (i_ctl.cap) begin
            r_match <= i_occ && (r_job.id == i_key);
        end
    end

    assign o_job   = r_job;
    assign o_match = r_match;

endmodule

// ----- rtl/tpjq_queue.sv -----
// One FIFO queue built as a row of cells with a fill count; the head is cell 0.
module tpjq_queue import tpjq_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cap,
    input  logic [ID_W-1:0] i_key,
    input  t_qcmd           i_cmd,
    output t_qstat          o_stat
);

    logic [QFILL_W-1:0]     r_fill;
    logic [QFILL_W-1:0]     n_fill;
    logic [QUEUE_DEPTH-1:0] w_match;
    logic [QUEUE_DEPTH-1:0] w_after_hit;
    t_job                   w_job [QUEUE_DEPTH];
    logic                   w_hit;
    logic                   w_full;
    logic                   w_empty;

    assign w_full  = (r_fill == QFILL_W'(QUEUE_DEPTH));
    assign w_empty = (r_fill == '0);
    assign w_hit   = |w_match;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_cell_ctl w_ctl;
        t_job      w_next;

        // Cells at and behind the first match move one place forward.
        assign w_after_hit[g] = |w_match[g:0];

        if (g < QUEUE_DEPTH - 1) begin : g_mid
            assign w_next = w_job[g+1];
        end else begin : g_last
            assign w_next = w_job[g];
        end

        always_comb begin
            w_ctl.cap   = i_cap;
            w_ctl.shift = (i_cmd.op == Q_POP) || (i_cmd.op == Q_POP_PUSH) ||
                          ((i_cmd.op == Q_CANCEL) && w_after_hit[g]);
            w_ctl.load  = ((i_cmd.op == Q_PUSH) && (r_fill == QFILL_W'(g))) ||
                          ((i_cmd.op == Q_POP_PUSH) &&
                           (r_fill - QFILL_W'(1) == QFILL_W'(g)));
        end

        tpjq_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_next  (w_next),
            .i_new   (i_cmd.job),
            .i_key   (i_key),
            .i_occ   (QFILL_W'(g) < r_fill),
            .o_job   (w_job[g]),
            .o_match (w_match[g])
        );
    end

    always_comb begin
        n_fill = r_fill;
        unique case (i_cmd.op)
            Q_PUSH:     n_fill = r_fill + QFILL_W'(1);
            Q_POP:      n_fill = r_fill - QFILL_W'(1);
            Q_CANCEL:   n_fill = w_hit ? r_fill - QFILL_W'(1) : r_fill;
            Q_NOP,
            Q_POP_PUSH: n_fill = r_fill;
            default:    n_fill = r_fill;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    assign o_stat.empty = w_empty;
    assign o_stat.full  = w_full;
    assign o_stat.hit   = w_hit;
    assign o_stat.head  = w_job[0];

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= QFILL_W'(QUEUE_DEPTH))
        else $error("queue fill count beyond depth");

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == Q_PUSH) |-> !w_full)
        else $error("push into a full queue");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((i_cmd.op == Q_POP) || (i_cmd.op == Q_POP_PUSH)) |-> !w_empty)
        else $error("pop from an empty queue");

endmodule

// ----- rtl/three_level_priority_job_queue.sv -----
// Top level of the three-level strict-priority job queue with cancel.
//
//  Channel  | Direction | Ports                      | Beat contents (low bit first)
//  ---------+-----------+----------------------------+-----------------------------------
//  request  | in        | i_s_tvalid/o_s_tready      | tuser: req_type; tdata: job_id,
//           |           | i_s_tdata/i_s_tuser        |   job_priority, page_count, print_error
//  result   | out       | o_m_tvalid/i_m_tready      | tuser: status; tdata: served_id,
//           |           | o_m_tdata/o_m_tuser        |   served_pages, served_level, was_failed
//
// A request has an accept cycle, in which every cell of every queue compares
// its job id against the request id, and an execute cycle, in which the queues
// shift, load and count and the result register is loaded.
// The id compare is registered in the cells, so the execute cycle only holds
// the first-match prefix and the shift control.
// Reset clears the three fill counts and the control; cell contents are not
// cleared and only cells below a fill count are ever read.
// A result that waits on a stalled output holds the next request in the
// execute cycle; a request of the unused type is accepted and gives no beat.
module three_level_priority_job_queue import tpjq_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // [15:0] job_id, [17:16] job_priority, [33:18] page_count, [34] print_error
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // [1:0] req_type
    input  logic [1:0]            i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [15:0] served_id, [31:16] served_pages, [33:32] served_level,
    // [34] served_was_failed
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    // [2:0] status
    output logic [2:0]            o_m_tuser
);

    t_state r_state;
    t_state n_state;

    // Request held from the accept cycle into the execute cycle.
    t_req               r_req;
    logic [ID_W-1:0]    r_id;
    logic [1:0]         r_prio;
    logic [PAGES_W-1:0] r_pages;
    logic               r_perr;

    // Result register.
    logic               r_m_valid;
    t_status            r_sts;
    t_job               r_served;
    logic [1:0]         r_level;

    logic               w_accept;
    logic               w_go;
    t_qcmd              w_cmd  [NUM_QUEUES];
    t_qstat             w_stat [NUM_QUEUES];
    t_status            w_sts;
    t_job               w_served;
    logic [1:0]         w_level;
    t_job               w_new;
    t_job               w_failed;
    logic [1:0]         w_add_q;

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    // The execute cycle completes once the result register is free.
    assign w_go       = (r_state == ST_EXEC) && (!r_m_valid || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (t_req'(i_s_tuser) != REQ_NONE)) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (w_go) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req   <= t_req'(i_s_tuser);
            r_id    <= i_s_tdata[15:0];
            r_prio  <= i_s_tdata[17:16];
            r_pages <= i_s_tdata[33:18];
            r_perr  <= i_s_tdata[34];
        end
    end

    // Queue commands and the result of the request in the execute cycle.
    always_comb begin
        w_new.id     = r_id;
        w_new.pages  = r_pages;
        w_new.failed = 1'b0;
        w_failed     = w_new;
        w_sts        = STS_EMPTY;
        w_served     = '0;
        w_level      = LVL_NONE;
        w_add_q      = 2'(Q_LOW);
        for (int q = 0; q < NUM_QUEUES; q++) begin
            w_cmd[q].op  = Q_NOP;
            w_cmd[q].job = w_new;
        end

        if (r_prio == PRIO_HIGH) begin
            w_add_q = 2'(Q_HIGH);
        end else if (r_prio == PRIO_MED) begin
            w_add_q = 2'(Q_MED);
        end

        if (w_go) begin
            unique case (r_req)
                REQ_ADD: begin
                    if (w_stat[w_add_q].full) begin
                        w_sts = STS_ADD_FULL;
                    end else begin
                        w_sts = STS_ADDED;
                        w_cmd[w_add_q].op = Q_PUSH;
                    end
                end
                REQ_PROC: begin
                    // Serve the highest queue that holds a job.
                    priority if (!w_stat[Q_HIGH].empty) begin
                        w_served = w_stat[Q_HIGH].head;
                        w_level  = LVL_HIGH;
                    end else if (!w_stat[Q_MED].empty) begin
                        w_served = w_stat[Q_MED].head;
                        w_level  = LVL_MED;
                    end else if (!w_stat[Q_LOW].empty) begin
                        w_served = w_stat[Q_LOW].head;
                        w_level  = LVL_LOW;
                    end
                    w_failed        = w_served;
                    w_failed.failed = 1'b1;
                    w_cmd[Q_HIGH].job = w_failed;

                    if (w_level == LVL_HIGH) begin
                        // Taking the head frees a cell, so the requeue always fits.
                        w_cmd[Q_HIGH].op = r_perr ? Q_POP_PUSH : Q_POP;
                        w_sts = r_perr ? STS_FAIL_REQ : STS_DONE;
                    end else if (w_level != LVL_NONE) begin
                        if (w_level == LVL_MED) begin
                            w_cmd[Q_MED].op = Q_POP;
                        end else begin
                            w_cmd[Q_LOW].op = Q_POP;
                        end
                        if (!r_perr) begin
                            w_sts = STS_DONE;
                        end else if (w_stat[Q_HIGH].full) begin
                            w_sts = STS_FAIL_DROP;
                        end else begin
                            w_sts = STS_FAIL_REQ;
                            w_cmd[Q_HIGH].op = Q_PUSH;
                        end
                    end else begin
                        w_sts = STS_EMPTY;
                    end
                end
                REQ_CANCEL: begin
                    for (int q = 0; q < NUM_QUEUES; q++) begin
                        w_cmd[q].op = Q_CANCEL;
                    end
                    w_sts = (w_stat[Q_HIGH].hit || w_stat[Q_MED].hit || w_stat[Q_LOW].hit)
                            ? STS_CANCELED : STS_NOT_FOUND;
                end
                default: w_sts = STS_EMPTY;
            endcase
        end
    end

    for (genvar q = 0; q < NUM_QUEUES; q++) begin : g_queue
        tpjq_queue u_queue (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cap   (w_accept),
            .i_key   (i_s_tdata[15:0]),
            .i_cmd   (w_cmd[q]),
            .o_stat  (w_stat[q])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_go) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_sts    <= w_sts;
            r_served <= w_served;
            r_level  <= w_level;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tuser  = r_sts;
    assign o_m_tdata  = {5'd0, r_served.failed, r_level, r_served.pages, r_served.id};

    a_valid_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_state == ST_EXEC))
        else $error("result beat without an execute cycle");

    a_served_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && (r_req != REQ_PROC)) |=> (o_m_tdata[33:32] == LVL_NONE))
        else $error("served level set on a request that serves no job");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("result beat changed while stalled");

endmodule
